[rtl/core/lce_pkg.sv]
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types and constants of the linear convolution engine: item kinds,
// controller states, and the command and status words that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lce_pkg;

  // Fixed widths of the result word
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W   = 6;

  // Saturation limits of the result value
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Item kinds; the fourth code means nothing and is ignored
  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_RUN    = 2'd2
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MAC   = 2'd1,
    ST_DRAIN = 2'd2
  } ctrl_state_e;

  // One multiply-accumulate term issued by the controller
  typedef struct packed {
    logic             issue;      // term is valid this cycle
    logic             first;      // first term of an output: restart the sum
    logic             last_term;  // last term of an output: emit the sum
    logic             final_out;  // this output is the last of the run
    logic [IDX_W-1:0] index;      // output position
  } mac_cmd_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic run_done;  // last result word of the run is on the output now
  } dp_status_t;

endpackage

[rtl/core/lce_ram.sv]
// ----------------------------------------------------------------------------
// lce_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lce_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lce_ctrl.sv]
// ----------------------------------------------------------------------------
// lce_ctrl
// Controller of the convolution engine: takes command words, keeps the two
// sequence lengths, and walks the output index n and the term index m over
// the valid band of each output, issuing one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
module lce_ctrl
  import lce_pkg::*;
#(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic [1:0]                 kind_i,
  output logic                       busy,
  input  dp_status_t                 status_i,
  output mac_cmd_t                   cmd_o,
  output logic                       wr_a_o,
  output logic                       wr_b_o,
  output logic [$clog2(MAX_LEN)-1:0] waddr_a_o,
  output logic [$clog2(MAX_LEN)-1:0] waddr_b_o,
  output logic [$clog2(MAX_LEN)-1:0] raddr_a_o,
  output logic [$clog2(MAX_LEN)-1:0] raddr_b_o
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned NW    = $clog2(2 * MAX_LEN - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);

  ctrl_state_e      state_q, state_d;
  logic [LEN_W-1:0] len_a_q, len_a_d;
  logic [LEN_W-1:0] len_b_q, len_b_d;
  logic [NW-1:0]    n_q, n_d;
  logic [AW-1:0]    m_q, m_d;

  logic          accept;
  kind_e         kind;
  logic [NW-1:0] len_a_n, len_b_n, total_m1, n_next;
  logic [AW-1:0] m_hi, m_lo_next;
  logic          last_term, final_term, run_ok;

  assign accept = start && (state_q == ST_IDLE);
  assign kind   = kind_e'(kind_i);
  assign run_ok = (len_a_q != '0) && (len_b_q != '0);

  // Band of terms for the current output
  assign len_a_n   = NW'(len_a_q);
  assign len_b_n   = NW'(len_b_q);
  assign total_m1  = len_a_n + len_b_n - NW'(2);
  assign n_next    = n_q + NW'(1);
  assign m_hi      = (n_q < len_b_n) ? AW'(n_q) : AW'(len_b_n - NW'(1));
  assign m_lo_next = (n_next >= len_a_n) ? AW'(n_next - len_a_n + NW'(1)) : '0;
  assign last_term  = (m_q == m_hi);
  assign final_term = last_term && (n_q == total_m1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind == KIND_RUN) && run_ok) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (final_term) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.run_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and counter updates
  always_comb begin
    busy      = (state_q != ST_IDLE);
    cmd_o     = '0;
    wr_a_o    = 1'b0;
    wr_b_o    = 1'b0;
    waddr_a_o = AW'(len_a_q);
    waddr_b_o = AW'(len_b_q);
    raddr_b_o = m_q;
    raddr_a_o = AW'(n_q - NW'(m_q));
    len_a_d   = len_a_q;
    len_b_d   = len_b_q;
    n_d       = n_q;
    m_d       = m_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOAD_A: begin
              // drop the sample once the sequence is full
              if (len_a_q < LEN_FULL) begin
                wr_a_o  = 1'b1;
                len_a_d = len_a_q + LEN_W'(1);
              end
            end
            KIND_LOAD_B: begin
              if (len_b_q < LEN_FULL) begin
                wr_b_o  = 1'b1;
                len_b_d = len_b_q + LEN_W'(1);
              end
            end
            KIND_RUN: begin
              n_d = '0;
              m_d = '0;
              // an empty sequence gives no output but still clears both
              if (!run_ok) begin
                len_a_d = '0;
                len_b_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.issue     = 1'b1;
        cmd_o.first     = (n_q == '0) || (m_q == AW'(0) && n_q < len_a_n) ||
                          (n_q >= len_a_n && m_q == AW'(n_q - len_a_n + NW'(1)));
        cmd_o.last_term = last_term;
        cmd_o.final_out = final_term;
        cmd_o.index     = IDX_W'(n_q);
        if (last_term) begin
          n_d = n_next;
          m_d = m_lo_next;
        end else begin
          m_d = m_q + AW'(1);
        end
        if (final_term) begin
          len_a_d = '0;
          len_b_d = '0;
        end
      end
      ST_DRAIN: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_a_q <= '0;
      len_b_q <= '0;
      n_q     <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      len_a_q <= len_a_d;
      len_b_q <= len_b_d;
      n_q     <= n_d;
      m_q     <= m_d;
    end
  end

  // The term index stays inside the band of the current output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (m_q <= m_hi))
    else $error("term index ran past the band of the output");

  // The final term ends the run and clears both lengths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.final_out) |=>
      (state_q == ST_DRAIN && len_a_q == '0 && len_b_q == '0))
    else $error("run did not close after its final term");

  // Lengths never pass the capacity of the stores
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= LEN_FULL) && (len_b_q <= LEN_FULL))
    else $error("sequence length above capacity");

endmodule

[rtl/core/lce_dpath.sv]
// ----------------------------------------------------------------------------
// lce_dpath
// Datapath of the convolution engine: the two sample stores, one pipelined
// multiply-accumulate unit, and the rounding and saturation of each sum.
// ----------------------------------------------------------------------------
module lce_dpath
  import lce_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 32,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  input  mac_cmd_t                   cmd_i,
  input  logic                       wr_a_i,
  input  logic                       wr_b_i,
  input  logic [$clog2(MAX_LEN)-1:0] waddr_a_i,
  input  logic [$clog2(MAX_LEN)-1:0] waddr_b_i,
  input  logic [$clog2(MAX_LEN)-1:0] raddr_a_i,
  input  logic [$clog2(MAX_LEN)-1:0] raddr_b_i,
  output dp_status_t                 status_o,
  output logic                       strobe_o,
  output logic [VALUE_W-1:0]         value_o,
  output logic [IDX_W-1:0]           index_o,
  output logic                       last_o
);

  localparam int unsigned AW     = $clog2(MAX_LEN);
  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W  = PROD_W + AW;
  localparam int unsigned FRAC   = SAMPLE_BITS - 1;
  localparam int unsigned RND_W  = (ACC_W + 1 > VALUE_W + 1) ? ACC_W + 1 : VALUE_W + 1;
  localparam logic signed [RND_W-1:0] HALF =
    {{(RND_W-1){1'b0}}, 1'b1} << (FRAC - 1);
  localparam logic signed [RND_W-1:0] SAT_HI =
    {{(RND_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO =
    {{(RND_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] a_rd, b_rd;
  mac_cmd_t               s1_q, s2_q, s3_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [RND_W-1:0]  rnd_sum, rnd_shr;
  logic [VALUE_W-1:0]       value_d, value_q;
  logic [IDX_W-1:0]         index_q;
  logic                     strobe_q, last_q;

  // Sample stores
  lce_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_a_i),
    .waddr_i (waddr_a_i),
    .wdata_i (sample_i),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr_a_i),
    .rdata_o (a_rd)
  );

  lce_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_b_i),
    .waddr_i (waddr_b_i),
    .wdata_i (sample_i),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr_b_i),
    .rdata_o (b_rd)
  );

  // Exact product of the two samples
  assign prod_d = $signed(a_rd) * $signed(b_rd);

  // Restart the sum on the first term, else add the product
  always_comb begin
    acc_d = acc_q;
    if (s2_q.issue) begin
      acc_d = (s2_q.first ? '0 : acc_q) + {{AW{prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Round half up to the output scale, then saturate
  always_comb begin
    rnd_sum = {{(RND_W-ACC_W){acc_q[ACC_W-1]}}, acc_q} + HALF;
    rnd_shr = rnd_sum >>> FRAC;
    if (rnd_shr > SAT_HI) begin
      value_d = VALUE_MAX;
    end else if (rnd_shr < SAT_LO) begin
      value_d = VALUE_MIN;
    end else begin
      value_d = rnd_shr[VALUE_W-1:0];
    end
  end

  // Pipeline control tags and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s2_q     <= '0;
      s3_q     <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      index_q  <= '0;
    end else begin
      s1_q     <= cmd_i;
      s2_q     <= s1_q;
      s3_q     <= s2_q;
      strobe_q <= s3_q.issue && s3_q.last_term;
      last_q   <= s3_q.issue && s3_q.last_term && s3_q.final_out;
      index_q  <= s3_q.index;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (s3_q.issue && s3_q.last_term) begin
      value_q <= value_d;
    end
  end

  assign strobe_o          = strobe_q;
  assign value_o           = value_q;
  assign index_o           = index_q;
  assign last_o            = last_q;
  assign status_o.run_done = strobe_q && last_q;

endmodule

[rtl/core/linear_convolution_engine.sv]
// ----------------------------------------------------------------------------
// linear_convolution_engine
// Full linear convolution of two signed sample sequences on one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a clock edge where start is high and busy is
//   low. kind 0 appends sample_i to sequence A, kind 1 appends it to B; a
//   sample for a sequence that already holds MAX_LEN entries is dropped.
//   Loads leave busy low, so they may come back to back.
//   kind 2 runs the convolution: lenA+lenB-1 result words follow in index
//   order, each for exactly one cycle with strobe_o high, the final one with
//   last_o high. The receiver cannot stall; it must take every word.
//   A run issues one multiply term per cycle, lenA*lenB terms in total;
//   each term passes in order through the store read, the multiplier, the
//   accumulator and the output register, and the multiplier issue loop sets
//   the rate. Words follow one band of terms apart, a band holding at most
//   min(lenA,lenB) terms. busy stays high through the cycle of the final
//   word and falls at the next edge. A run with an empty sequence emits
//   nothing. Every run clears both lengths. Values are rounded half up to
//   SAMPLE_BITS-1 fraction bits and saturated to 32 bits.
//   Reset clears both lengths and the controller; store contents need no
//   clearing and there is no start-up sweep.
// ----------------------------------------------------------------------------
module linear_convolution_engine
  import lce_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 32,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             kind_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   strobe_o,
  output logic [VALUE_W-1:0]     value_o,
  output logic [IDX_W-1:0]       index_o,
  output logic                   last_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);

  mac_cmd_t      cmd;
  dp_status_t    status;
  logic          wr_a, wr_b;
  logic [AW-1:0] waddr_a, waddr_b, raddr_a, raddr_b;

  // Sequencer
  lce_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .kind_i    (kind_i),
    .busy      (busy),
    .status_i  (status),
    .cmd_o     (cmd),
    .wr_a_o    (wr_a),
    .wr_b_o    (wr_b),
    .waddr_a_o (waddr_a),
    .waddr_b_o (waddr_b),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b)
  );

  // Stores and arithmetic
  lce_dpath #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .cmd_i     (cmd),
    .wr_a_i    (wr_a),
    .wr_b_i    (wr_b),
    .waddr_a_i (waddr_a),
    .waddr_b_i (waddr_b),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .status_o  (status),
    .strobe_o  (strobe_o),
    .value_o   (value_o),
    .index_o   (index_o),
    .last_o    (last_o)
  );

endmodule
